### src/dgm_pkg.sv
// Package with shared constants and types for the ducking group mixer.
`timescale 1ns / 1ps
package dgm_pkg;
   localparam int Groups = 4;
   localparam int Rules = 4;
   localparam int Channels = 2;
   localparam int BlockSamples = 64;
   localparam int AddrW = 6;
   localparam int CntW = 7;
   localparam int ChanW = 3;
   localparam int CfgIdxW = 3;
   localparam int CfgDataW = 40;
   localparam int WordW = 64;
   localparam logic [16:0] Unity = 17'd32768;

   typedef struct packed {
      logic signed [15:0] group_zero_sample;
      logic signed [15:0] group_one_sample;
      logic signed [15:0] group_two_sample;
      logic signed [15:0] group_three_sample;
      logic block_end;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] mixed_sample;
      logic run_last;
   } rsp_payload_type;
endpackage

### src/dgm_req_if.sv
// Valid-ready channel interface that carries one input item.
`timescale 1ns / 1ps
interface dgm_req_if;
   logic valid;
   logic ready;
   dgm_pkg::req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### src/dgm_rsp_if.sv
// Valid-ready channel interface that carries one result item.
`timescale 1ns / 1ps
interface dgm_rsp_if;
   logic valid;
   logic ready;
   dgm_pkg::rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### src/dgm_ram.sv
// Generic single-port-write, one-read RAM with a registered read.
`timescale 1ns / 1ps
module dgm_ram #(
   parameter int Width = 64,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### src/ducking_group_mixer_unit.sv
// Top level of the ducking group mixer: sample buffer, sequencer and shared multiplier.
`timescale 1ns / 1ps
// An item that does not close a block is stored. A closed block takes a peak pass (read each
// item, check four groups), then each item is read, mixed in four multiply steps and output;
// the first item of each frame adds an envelope and a multiply step per rule and a gain update.
// The block is not ready while a block is processed; a result waits in an output register.
// Synchronous active-high reset clears control state, envelopes and config; gains go to unity.
module ducking_group_mixer_unit (
   input  logic                         clock,
   input  logic                         reset,
   dgm_req_if.sink                      req,
   dgm_rsp_if.source                    rsp,
   input  logic                         csr_write_enable,
   input  logic [dgm_pkg::CfgIdxW-1:0]  csr_index,
   input  logic [dgm_pkg::CfgDataW-1:0] csr_write_data
);
   typedef enum logic [3:0] {
      ST_FILL, ST_PEAK_RD, ST_PEAK, ST_RULE, ST_MUL, ST_ITEM_RD, ST_ITEM_MUL,
      ST_ITEM_OUT, ST_WAIT
   } state_type;

   // Configuration registers.
   logic [39:0] levels_ff [dgm_pkg::Rules];
   logic [31:0] steps_ff [dgm_pkg::Rules];

   state_type state_ff;
   logic [dgm_pkg::CntW-1:0] fill_ff;
   logic [dgm_pkg::AddrW-1:0] idx_ff;
   logic [1:0] grp_ff;
   logic [1:0] rule_ff;
   logic [dgm_pkg::ChanW-1:0] chan_ff;
   logic [16:0] peak_ff [dgm_pkg::Groups];
   logic [16:0] env_ff [dgm_pkg::Rules];
   logic [16:0] gain_ff [dgm_pkg::Groups];
   logic [16:0] new_gain_ff [dgm_pkg::Groups];
   logic signed [35:0] acc_ff;
   logic [15:0] mixed_ff;
   logic last_ff;
   logic rsp_valid_ff;

   logic [dgm_pkg::WordW-1:0] rd_data;
   logic [dgm_pkg::AddrW-1:0] rd_addr;
   logic wr_en;
   logic [dgm_pkg::WordW-1:0] wr_data;

   assign req.ready = (state_ff == ST_FILL);
   assign wr_en = req.valid && req.ready;
   assign wr_data = {req.payload.group_three_sample, req.payload.group_two_sample,
                     req.payload.group_one_sample, req.payload.group_zero_sample};
   assign rd_addr = idx_ff;

   dgm_ram #(.Width(dgm_pkg::WordW), .Depth(dgm_pkg::BlockSamples)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[dgm_pkg::AddrW-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Configuration writes; indexes beyond the list are ignored by the index width.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < dgm_pkg::Rules; r++) begin
            levels_ff[r] <= '0;
            steps_ff[r] <= '0;
         end
      end else if (csr_write_enable) begin
         if (csr_index[0]) begin
            steps_ff[csr_index[2:1]] <= csr_write_data[31:0];
         end else begin
            levels_ff[csr_index[2:1]] <= csr_write_data;
         end
      end
   end

   // Current rule fields and the shared multiplier operands.
   logic [39:0] lv;
   logic [31:0] st;
   logic [16:0] rule_peak;
   logic [16:0] env_next;
   logic [17:0] env_sum;
   logic signed [15:0] cur_sample;
   logic signed [17:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [35:0] product;
   logic [32:0] drop;
   logic [16:0] rule_gain;
   logic [16:0] abs_sample;

   assign lv = levels_ff[rule_ff];
   assign st = steps_ff[rule_ff];
   assign cur_sample = rd_data[16*grp_ff +: 16];
   assign abs_sample = cur_sample[15] ? 17'(-18'(cur_sample)) : 17'(cur_sample);

   // Peak over the rule's source groups.
   always_comb begin
      rule_peak = '0;
      for (int g = 0; g < dgm_pkg::Groups; g++) begin
         if (lv[g] && peak_ff[g] > rule_peak) begin
            rule_peak = peak_ff[g];
         end
      end
   end

   // Envelope step with saturation to the range zero to unity.
   always_comb begin
      env_sum = 18'(env_ff[rule_ff]) + 18'(st[15:0]);
      if (rule_peak > 17'(lv[23:8])) begin
         env_next = (env_sum > 18'(dgm_pkg::Unity)) ? dgm_pkg::Unity : env_sum[16:0];
      end else begin
         env_next = (env_ff[rule_ff] > 17'(st[31:16])) ?
                    env_ff[rule_ff] - 17'(st[31:16]) : '0;
      end
   end

   // The one multiplier serves both the gain drop and the sample mix.
   always_comb begin
      if (state_ff == ST_MUL) begin
         mul_a = 18'(lv[39:24]);
         mul_b = 18'(env_ff[rule_ff]);
      end else begin
         mul_a = 18'(cur_sample);
         mul_b = 18'(gain_ff[grp_ff]);
      end
   end
   assign product = mul_a * mul_b;
   assign drop = 33'(product) >> 15;
   assign rule_gain = (drop >= 33'(dgm_pkg::Unity)) ? '0 : dgm_pkg::Unity - drop[16:0];

   // Rounding toward minus infinity and saturation of the mixed sum.
   logic signed [20:0] shifted;
   logic [15:0] sat_val;
   assign shifted = 21'(acc_ff >>> 15);
   assign sat_val = (shifted > 21'sd32767) ? 16'h7fff :
                    (shifted < -21'sd32768) ? 16'h8000 : shifted[15:0];

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         fill_ff <= '0;
         idx_ff <= '0;
         grp_ff <= '0;
         rule_ff <= '0;
         chan_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int g = 0; g < dgm_pkg::Groups; g++) begin
            peak_ff[g] <= '0;
            gain_ff[g] <= dgm_pkg::Unity;
         end
         for (int r = 0; r < dgm_pkg::Rules; r++) begin
            env_ff[r] <= '0;
         end
      end else begin
         // A taken result leaves the output register unless a new one replaces it.
         if (rsp.valid && rsp.ready && state_ff != ST_ITEM_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_FILL: begin
               if (wr_en) begin
                  fill_ff <= fill_ff + 1'b1;
                  if (req.payload.block_end ||
                      fill_ff == dgm_pkg::CntW'(dgm_pkg::BlockSamples - 1)) begin
                     state_ff <= ST_PEAK_RD;
                     idx_ff <= '0;
                     grp_ff <= '0;
                     for (int g = 0; g < dgm_pkg::Groups; g++) begin
                        peak_ff[g] <= '0;
                     end
                  end
               end
            end
            ST_PEAK_RD: state_ff <= ST_PEAK;
            ST_PEAK: begin
               if (abs_sample > peak_ff[grp_ff]) begin
                  peak_ff[grp_ff] <= abs_sample;
               end
               grp_ff <= grp_ff + 1'b1;
               if (grp_ff == 2'd3) begin
                  if (7'(idx_ff) + 1'b1 == fill_ff) begin
                     idx_ff <= '0;
                     chan_ff <= '0;
                     state_ff <= ST_ITEM_RD;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                     state_ff <= ST_PEAK_RD;
                  end
               end
            end
            ST_ITEM_RD: begin
               grp_ff <= '0;
               acc_ff <= '0;
               if (chan_ff == '0) begin
                  rule_ff <= '0;
                  for (int g = 0; g < dgm_pkg::Groups; g++) begin
                     new_gain_ff[g] <= dgm_pkg::Unity;
                  end
                  state_ff <= ST_RULE;
               end else begin
                  state_ff <= ST_ITEM_MUL;
               end
            end
            ST_RULE: begin
               env_ff[rule_ff] <= env_next;
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               for (int g = 0; g < dgm_pkg::Groups; g++) begin
                  if (lv[4+g] && rule_gain < new_gain_ff[g]) begin
                     new_gain_ff[g] <= rule_gain;
                  end
               end
               if (rule_ff == 2'(dgm_pkg::Rules - 1)) begin
                  state_ff <= ST_WAIT;
               end else begin
                  rule_ff <= rule_ff + 1'b1;
                  state_ff <= ST_RULE;
               end
            end
            ST_WAIT: begin
               for (int g = 0; g < dgm_pkg::Groups; g++) begin
                  gain_ff[g] <= new_gain_ff[g];
               end
               state_ff <= ST_ITEM_MUL;
            end
            ST_ITEM_MUL: begin
               acc_ff <= acc_ff + product;
               grp_ff <= grp_ff + 1'b1;
               if (grp_ff == 2'd3) begin
                  state_ff <= ST_ITEM_OUT;
               end
            end
            ST_ITEM_OUT: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff <= 1'b1;
                  mixed_ff <= sat_val;
                  last_ff <= (7'(idx_ff) + 1'b1 == fill_ff);
                  if (7'(idx_ff) + 1'b1 == fill_ff) begin
                     fill_ff <= '0;
                     idx_ff <= '0;
                     state_ff <= ST_FILL;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                     chan_ff <= (chan_ff == dgm_pkg::ChanW'(dgm_pkg::Channels - 1)) ?
                                '0 : chan_ff + 1'b1;
                     state_ff <= ST_ITEM_RD;
                  end
               end
            end
            default: state_ff <= ST_FILL;
         endcase
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload.mixed_sample = mixed_ff;
   assign rsp.payload.run_last = last_ff;
endmodule

### test/tb_top.sv
// Self-checking testbench for the ducking group mixer unit.
`timescale 1ns / 1ps
module tb_top;
   typedef enum int {
      RegRuleZeroLevels  = 0,
      RegRuleZeroSteps   = 1,
      RegRuleOneLevels   = 2,
      RegRuleOneSteps    = 3,
      RegRuleTwoLevels   = 4,
      RegRuleTwoSteps    = 5,
      RegRuleThreeLevels = 6,
      RegRuleThreeSteps  = 7
   } csr_reg_type;

   localparam int WatchdogLimit = 20000;
   localparam int SettleCycles = 1200;
   localparam int HoldCycles = 400;

   // One row of the directed table: samples, block end, and an optional typed-in result.
   typedef struct {
      logic signed [15:0] s0, s1, s2, s3;
      logic               last;
      logic               has_fixed;
      logic signed [15:0] fixed_mix;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [dgm_pkg::CfgIdxW-1:0] csr_index = '0;
   logic [dgm_pkg::CfgDataW-1:0] csr_write_data = '0;

   dgm_req_if req_ch ();
   dgm_rsp_if rsp_ch ();

   ducking_group_mixer_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch.sink),
      .rsp              (rsp_ch.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Clock with a 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predictor state: registers, sample buffer, envelopes and gains.
   logic [39:0] mix_levels [4];
   logic [31:0] mix_steps [4];
   logic [63:0] mix_buffer [64];
   int mix_fixed [64];
   int unsigned mix_fill;
   int unsigned mix_peak [4];
   int unsigned mix_env [4];
   int unsigned mix_gain [4];

   // Expected results, oldest first, with an optional typed-in sample.
   dgm_pkg::rsp_payload_type mix_expected [$];
   int fixed_expected [$];

   int mismatches = 0;
   int items_sent = 0;
   int results_seen = 0;
   int blocks_seen = 0;
   int idle_cycles = 0;
   bit hold_request = 1'b0;
   bit hold_done = 1'b0;

   // Writes one register on the port and mirrors it in the predictor.
   task automatic write_reg(input csr_reg_type idx, input logic [39:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= dgm_pkg::CfgIdxW'(idx);
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (int'(idx) % 2 == 1) mix_steps[int'(idx) / 2] = value[31:0];
      else mix_levels[int'(idx) / 2] = value;
   endtask

   // Steps every rule envelope for one frame and recomputes the group gains.
   function automatic void step_envelopes();
      int unsigned peak, gain, drop;
      logic [15:0] thr, red, att, rel;
      for (int g = 0; g < 4; g++) mix_gain[g] = 32768;
      for (int r = 0; r < dgm_pkg::Rules; r++) begin
         thr = mix_levels[r][23:8];
         red = mix_levels[r][39:24];
         att = mix_steps[r][15:0];
         rel = mix_steps[r][31:16];
         peak = 0;
         for (int g = 0; g < dgm_pkg::Groups; g++)
            if (mix_levels[r][g] && mix_peak[g] > peak) peak = mix_peak[g];
         if (peak > thr) begin
            mix_env[r] += att;
            if (mix_env[r] > 32768) mix_env[r] = 32768;
         end else begin
            mix_env[r] = (mix_env[r] > rel) ? mix_env[r] - rel : 0;
         end
         drop = int'((longint'(red) * longint'(mix_env[r])) >>> 15);
         gain = (drop >= 32768) ? 0 : 32768 - drop;
         for (int g = 0; g < dgm_pkg::Groups; g++)
            if (mix_levels[r][4 + g] && gain < mix_gain[g]) mix_gain[g] = gain;
      end
   endfunction

   // Processes the buffered block into expected mixed samples.
   function automatic void mix_block();
      logic signed [15:0] s;
      longint acc, v;
      int unsigned a;
      for (int g = 0; g < 4; g++) begin
         mix_peak[g] = 0;
         if (g < dgm_pkg::Groups)
            for (int i = 0; i < mix_fill; i++) begin
               s = mix_buffer[i][16*g +: 16];
               a = (s < 0) ? -int'(s) : int'(s);
               if (a > mix_peak[g]) mix_peak[g] = a;
            end
      end
      for (int i = 0; i < mix_fill; i++) begin
         if (i % dgm_pkg::Channels == 0) step_envelopes();
         acc = 0;
         for (int g = 0; g < dgm_pkg::Groups; g++) begin
            s = mix_buffer[i][16*g +: 16];
            acc += longint'(s) * longint'(mix_gain[g]);
         end
         v = acc >>> 15;
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         mix_expected.push_back('{mixed_sample: 16'(v), run_last: (i + 1 == mix_fill)});
         fixed_expected.push_back(mix_fixed[i]);
      end
      mix_fill = 0;
   endfunction

   // Offers one item and waits until it is accepted; feeds the predictor.
   // The valid line stays high afterwards; callers drop it before a gap.
   task automatic send_item(input logic signed [15:0] s0, s1, s2, s3, input logic last,
                            input int fixed_mix);
      req_ch.payload <= '{s0, s1, s2, s3, last};
      req_ch.valid <= 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      mix_buffer[mix_fill] = {s3, s2, s1, s0};
      mix_fixed[mix_fill] = fixed_mix;
      mix_fill++;
      items_sent++;
      if (last || mix_fill >= dgm_pkg::BlockSamples) mix_block();
   endtask

   // Random sample: often any 16-bit value, sometimes full scale or a small value near zero.
   function automatic logic signed [15:0] rand_sample();
      unique case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'($urandom_range(0, 255)) - 16'sd128;
         default: return 16'($urandom);
      endcase
   endfunction

   // Stops offering and waits until every expected result has arrived.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (mix_expected.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   // Random register setting for one rule.
   function automatic logic [39:0] rand_levels();
      return {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 40000)),
              8'($urandom)};
   endfunction

   // Result checker: compares each accepted result with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (rsp_ch.payload.run_last) blocks_seen++;
         if (mix_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result: %0d %0b",
               rsp_ch.payload.mixed_sample, rsp_ch.payload.run_last);
         end else begin
            dgm_pkg::rsp_payload_type want;
            int fixed_val;
            want = mix_expected.pop_front();
            fixed_val = fixed_expected.pop_front();
            if (rsp_ch.payload.mixed_sample !== want.mixed_sample ||
                rsp_ch.payload.run_last !== want.run_last ||
                (fixed_val != -100000 && rsp_ch.payload.mixed_sample !== 16'(fixed_val))) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected %0d last %0b, got %0d last %0b",
                     want.mixed_sample, want.run_last,
                     rsp_ch.payload.mixed_sample, rsp_ch.payload.run_last);
            end
         end
      end
   end

   // Receiver stall pattern, with one long hold-off counted here.
   initial begin
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            rsp_ch.ready <= 1'b0;
            repeat (HoldCycles) @(negedge clock);
            hold_done = 1'b1;
         end
         if (items_sent < 60 || (items_sent / 40) % 3 == 1) rsp_ch.ready <= 1'b1;
         else rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Watchdog on cycles without any accepted item.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WatchdogLimit) begin
         $display("Watchdog expired after %0d idle cycles", idle_cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Main stimulus sequence.
   initial begin
      stim_row_type rows [$];
      int len;
      int target;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      for (int r = 0; r < 4; r++) begin
         mix_levels[r] = '0;
         mix_steps[r] = '0;
         mix_env[r] = 0;
         mix_gain[r] = 32768;
         mix_peak[r] = 0;
      end
      mix_fill = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table: unity gain after reset, so results are the saturated sums.
      rows.push_back('{16'sh7fff, 0, 0, 0, 0, 1, 16'sh7fff});
      rows.push_back('{16'sh8000, 0, 0, 0, 1, 1, 16'sh8000});
      rows.push_back('{16'sh7fff, 16'sh7fff, 0, 0, 0, 1, 16'sh7fff});
      rows.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0, 1, 16'sh8000});
      rows.push_back('{-16'sd1, 0, 0, 0, 1, 1, -16'sd1});
      rows.push_back('{16'sh5555, 16'shaaaa, 16'sh00ff, 16'shff00, 1, 0, 0});
      foreach (rows[i])
         send_item(rows[i].s0, rows[i].s1, rows[i].s2, rows[i].s3, rows[i].last,
                   rows[i].has_fixed ? int'(rows[i].fixed_mix) : -100000);
      drain();

      // Ducking rules: overshooting reduction, full steps, odd block length.
      write_reg(RegRuleZeroLevels, {16'hffff, 16'h1000, 4'b1110, 4'b0001});
      write_reg(RegRuleZeroSteps, {16'h0100, 16'hffff});
      write_reg(RegRuleOneLevels, {16'h4000, 16'h0000, 4'b0001, 4'b0010});
      write_reg(RegRuleOneSteps, {16'hffff, 16'h2000});
      write_reg(RegRuleTwoLevels, {16'h8000, 16'hffff, 4'b1111, 4'b1111});
      write_reg(RegRuleTwoSteps, 40'hffff_ffff);
      write_reg(RegRuleThreeLevels, {16'h2000, 16'h7fff, 4'b0100, 4'b1000});
      write_reg(RegRuleThreeSteps, {16'h0001, 16'h8000});
      for (int i = 0; i < 3; i++)
         send_item(16'sh7000, 16'sh8000, 16'sh4000, -16'sd300, i == 2, -100000);
      for (int i = 0; i < dgm_pkg::BlockSamples; i++)   // block that fills the buffer
         send_item(rand_sample(), rand_sample(), rand_sample(), rand_sample(), 0, -100000);
      drain();

      // Random phases with new settings, bursts and gaps.
      for (int phase = 0; phase < 5; phase++) begin
         for (int r = 0; r < 4; r++) begin
            write_reg(csr_reg_type'(2 * r), (phase == 4) ? 40'hff_ffff_ffff : rand_levels());
            write_reg(csr_reg_type'(2 * r + 1), (phase == 3) ? 40'h0 : 40'($urandom));
         end
         if (phase == 2) hold_request = 1'b1;
         target = 90 + (phase + 1) * 64;
         while (items_sent < target) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 9);
            if (len > target - items_sent) len = target - items_sent;
            for (int i = 0; i < len; i++) begin
               send_item(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                         i == len - 1, -100000);
               if ($urandom_range(0, 4) == 0) begin
                  req_ch.valid <= 1'b0;
                  repeat ($urandom_range(1, 12)) @(negedge clock);
               end
            end
         end
         drain();
      end

      $display("Run covered %0d input items in %0d blocks, %0d results checked.",
               items_sent, blocks_seen, results_seen);
      if (mismatches == 0 && mix_expected.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches, %0d results outstanding", mismatches, mix_expected.size());
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule
